[rtl/bhrl_pkg.sv]
// Shared types, constants and helper functions of the boot history ring logger.
`timescale 1ns / 1ps
package bhrl_pkg;

    localparam int RING_DEPTH = 8;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int CMDQ_DEPTH = 2;
    localparam int QPTR_W     = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QFILL_W    = $clog2(CMDQ_DEPTH + 1);
    localparam int UPTIME_W   = 16;

    localparam logic [1:0] REQ_BOOT = 2'd0;
    localparam logic [1:0] REQ_BEAT = 2'd1;
    localparam logic [1:0] REQ_HIST = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef enum logic [1:0] {
        CMD_BOOT,
        CMD_BEAT,
        CMD_HIST
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [31:0]           cause;
        logic                  cause_set;
        logic [UPTIME_W-1:0]   uptime;
        logic [7:0]            max_records;
    } t_cmd;

    typedef struct packed {
        logic empty;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic [31:0]         boot_number;
        logic [31:0]         cause_bits;
        logic                warm_flag;
        logic                cause_valid;
        logic [UPTIME_W-1:0] prior_uptime;
    } t_ring_word;

    localparam int RING_W = $bits(t_ring_word);

    typedef struct packed {
        t_ring_word body;
        logic       record_present;
        logic       last_record;
    } t_rec;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_LD
    } t_back_state;

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        slot_next = (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    // Slot of the oldest of the n newest records, modulo the ring depth.
    function automatic logic [SLOT_W-1:0] ring_start(input logic [SLOT_W-1:0] ws,
                                                     input logic [CNT_W-1:0]  n);
        logic [CNT_W+SLOT_W:0] t;
        t = (CNT_W+SLOT_W+1)'(ws) + (CNT_W+SLOT_W+1)'(RING_DEPTH)
            - (CNT_W+SLOT_W+1)'(n);
        if (t >= (CNT_W+SLOT_W+1)'(RING_DEPTH)) begin
            t = t - (CNT_W+SLOT_W+1)'(RING_DEPTH);
        end
        ring_start = t[SLOT_W-1:0];
    endfunction

endpackage

[rtl/bhrl_channels.sv]
// Valid/ready channel interfaces for requests and history records.
`timescale 1ns / 1ps
interface bhrl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] reset_cause;
    logic        cause_read_ok;
    logic [31:0] uptime_seconds;
    logic [7:0]  max_records;

    modport source (output valid, req_type, reset_cause, cause_read_ok,
                    uptime_seconds, max_records, input ready);
    modport sink (input valid, req_type, reset_cause, cause_read_ok,
                  uptime_seconds, max_records, output ready);
endinterface

interface bhrl_rec_if;
    logic        valid;
    logic        ready;
    logic [31:0] boot_number;
    logic [31:0] cause_bits;
    logic        warm_flag;
    logic        cause_valid;
    logic [15:0] prior_uptime;
    logic        record_present;
    logic        last_record;

    modport source (output valid, boot_number, cause_bits, warm_flag, cause_valid,
                    prior_uptime, record_present, last_record, input ready);
    modport sink (input valid, boot_number, cause_bits, warm_flag, cause_valid,
                  prior_uptime, record_present, last_record, output ready);
    modport monitor (input valid, ready, boot_number, cause_bits, warm_flag,
                     cause_valid, prior_uptime, record_present, last_record);
endinterface

[rtl/boot_history_ring_logger_core.sv]
// Top level of the boot history ring logger: front end, command queue, back end.
// A boot record or empty marker passes through the command queue and the output register; the
//   first record of a history read passes through the queue, a ring read and the output load.
// A history request does one ring read and one output load per record; boot events and
//   heartbeats take no ring read. Output loads wait while the output register is stalled.
// Up to 2 requests wait in the command queue while the back end is busy.
// Reset (synchronous, active low) drops retained history; ring contents need no clearing.
`timescale 1ns / 1ps
module boot_history_ring_logger_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bhrl_req_if.sink    i_req,
    bhrl_rec_if.source  o_rec
);
    import bhrl_pkg::*;

    // front end to queue
    logic    w_push;
    t_cmd    w_cmd;
    logic    w_full;

    // queue to back end
    t_q_head w_head;
    logic    w_pop;

    // back end output register
    logic    w_rec_valid;
    t_rec    w_rec;

    // Decode and pre-condition requests; drop unused request codes.
    bhrl_front u_front (
        .i_req  (i_req),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_cmd)
    );

    // Hold accepted commands so the front keeps taking items while records drain.
    bhrl_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Advance history state, write boots into the ring, replay on request.
    bhrl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_rec_valid (w_rec_valid),
        .o_rec       (w_rec),
        .i_rec_ready (o_rec.ready)
    );

    assign o_rec.valid          = w_rec_valid;
    assign o_rec.boot_number    = w_rec.body.boot_number;
    assign o_rec.cause_bits     = w_rec.body.cause_bits;
    assign o_rec.warm_flag      = w_rec.body.warm_flag;
    assign o_rec.cause_valid    = w_rec.body.cause_valid;
    assign o_rec.prior_uptime   = w_rec.body.prior_uptime;
    assign o_rec.record_present = w_rec.record_present;
    assign o_rec.last_record    = w_rec.last_record;
endmodule

[rtl/bhrl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bhrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[rtl/bhrl_front.sv]
// Request front end: accept, decode and pre-condition request items.
`timescale 1ns / 1ps
module bhrl_front (
    bhrl_req_if.sink          i_req,
    input  logic              i_full,
    output logic              o_push,
    output bhrl_pkg::t_cmd    o_cmd
);
    import bhrl_pkg::*;

    logic w_take;

    assign i_req.ready = !i_full;
    assign w_take      = i_req.valid && !i_full;

    always_comb begin
        o_push            = 1'b0;
        o_cmd.kind        = CMD_BEAT;
        o_cmd.cause       = i_req.cause_read_ok ? i_req.reset_cause : 32'd0;
        o_cmd.cause_set   = i_req.cause_read_ok && (i_req.reset_cause != 32'd0);
        o_cmd.max_records = i_req.max_records;
        // saturate uptime to the stored width
        o_cmd.uptime      = (i_req.uptime_seconds > 32'(UPTIME_W'('1)))
                            ? UPTIME_W'('1) : i_req.uptime_seconds[UPTIME_W-1:0];
        unique case (i_req.req_type)
            REQ_BOOT: begin
                o_cmd.kind = CMD_BOOT;
                o_push     = w_take;
            end
            REQ_BEAT: begin
                o_cmd.kind = CMD_BEAT;
                o_push     = w_take;
            end
            REQ_HIST: begin
                o_cmd.kind = CMD_HIST;
                o_push     = w_take;
            end
            REQ_NONE: begin
                o_push = 1'b0;
            end
        endcase
    end
endmodule

[rtl/bhrl_cmdq.sv]
// Small command queue between front end and back end.
`timescale 1ns / 1ps
module bhrl_cmdq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bhrl_pkg::t_cmd      i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output bhrl_pkg::t_q_head   o_head
);
    import bhrl_pkg::*;

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QFILL_W-1:0] r_fill, n_fill;
    logic               w_pop;

    assign o_full       = (r_fill == QFILL_W'(CMDQ_DEPTH));
    assign o_head.empty = (r_fill == '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign w_pop        = i_pop && !o_head.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !w_pop) begin
            n_fill = r_fill + QFILL_W'(1);
        end else if (w_pop && !i_push) begin
            n_fill = r_fill - QFILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end
endmodule

[rtl/bhrl_back.sv]
// Back end: history state, ring storage, replay sequencer and output register.
`timescale 1ns / 1ps
module bhrl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bhrl_pkg::t_q_head  i_head,
    output logic               o_pop,
    output logic               o_rec_valid,
    output bhrl_pkg::t_rec     o_rec,
    input  logic               i_rec_ready
);
    import bhrl_pkg::*;

    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    t_back_state          r_state, n_state;
    logic                 r_hv, n_hv;
    logic [31:0]          r_boot, n_boot;
    logic [SLOT_W-1:0]    r_ws, n_ws;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [UPTIME_W-1:0]  r_up, n_up;
    logic [SLOT_W-1:0]    r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]     r_left, n_left;
    logic                 r_out_valid, n_out_valid;
    t_rec                 r_out, n_out;

    logic                 w_out_free;
    logic [CNT_W-1:0]     w_hist_n;
    logic                 w_load;
    t_rec                 w_rec;
    logic                 w_wr_en;
    logic [SLOT_W-1:0]    w_wr_addr;
    t_ring_word           w_wr_word;
    logic                 w_rd_en;
    logic [RING_W-1:0]    w_rd_data;
    t_ring_word           w_rd_word;
    logic                 w_warm;
    logic [SLOT_W-1:0]    w_slot;

    assign w_out_free = !r_out_valid || i_rec_ready;
    assign w_rd_word  = t_ring_word'(w_rd_data);
    assign w_warm     = r_hv;
    assign w_slot     = r_hv ? r_ws : '0;

    always_comb begin
        if (!r_hv) begin
            w_hist_n = '0;
        end else if (CMP_W'(i_head.cmd.max_records) < CMP_W'(r_cnt)) begin
            w_hist_n = CNT_W'(i_head.cmd.max_records);
        end else begin
            w_hist_n = r_cnt;
        end
    end

    bhrl_ram #(
        .WIDTH (RING_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_word),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_head.empty && i_head.cmd.kind == CMD_HIST && w_out_free
                    && w_hist_n != '0) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (w_out_free) begin
                    n_state = (r_left == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_pop     = 1'b0;
        w_load    = 1'b0;
        w_rec     = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = w_slot;
        w_wr_word = '0;
        w_rd_en   = 1'b0;
        n_hv      = r_hv;
        n_boot    = r_boot;
        n_ws      = r_ws;
        n_cnt     = r_cnt;
        n_up      = r_up;
        n_rd_idx  = r_rd_idx;
        n_left    = r_left;
        unique case (r_state)
            S_IDLE: begin
                if (!i_head.empty) begin
                    case (i_head.cmd.kind)
                        CMD_BEAT: begin
                            o_pop = 1'b1;
                            n_up  = i_head.cmd.uptime;
                        end
                        CMD_BOOT: begin
                            if (w_out_free) begin
                                // a cold boot restarts counter, slot and count
                                o_pop                 = 1'b1;
                                w_wr_word.boot_number = w_warm ? r_boot + 32'd1 : 32'd1;
                                w_wr_word.cause_bits  = i_head.cmd.cause;
                                w_wr_word.warm_flag   = w_warm;
                                w_wr_word.cause_valid = i_head.cmd.cause_set;
                                w_wr_word.prior_uptime = w_warm ? r_up : '0;
                                w_wr_en               = 1'b1;
                                w_load                = 1'b1;
                                w_rec.body            = w_wr_word;
                                w_rec.record_present  = 1'b1;
                                w_rec.last_record     = 1'b1;
                                n_hv                  = 1'b1;
                                n_boot                = w_wr_word.boot_number;
                                n_ws                  = slot_next(w_slot);
                                n_up                  = '0;
                                if (!w_warm) begin
                                    n_cnt = CNT_W'(1);
                                end else if (r_cnt < CNT_W'(RING_DEPTH)) begin
                                    n_cnt = r_cnt + CNT_W'(1);
                                end
                            end
                        end
                        CMD_HIST: begin
                            if (w_out_free) begin
                                o_pop = 1'b1;
                                if (w_hist_n == '0) begin
                                    // empty marker
                                    w_load            = 1'b1;
                                    w_rec.last_record = 1'b1;
                                end else begin
                                    n_rd_idx = ring_start(r_ws, w_hist_n);
                                    n_left   = w_hist_n;
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
            end
            S_LD: begin
                if (w_out_free) begin
                    w_load               = 1'b1;
                    w_rec.body           = w_rd_word;
                    w_rec.record_present = 1'b1;
                    w_rec.last_record    = (r_left == CNT_W'(1));
                    n_left               = r_left - CNT_W'(1);
                    n_rd_idx             = slot_next(r_rd_idx);
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out       = w_rec;
        end else if (i_rec_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hv        <= 1'b0;
            r_boot      <= '0;
            r_ws        <= '0;
            r_cnt       <= '0;
            r_up        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hv        <= n_hv;
            r_boot      <= n_boot;
            r_ws        <= n_ws;
            r_cnt       <= n_cnt;
            r_up        <= n_up;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_left   <= n_left;
        r_out    <= n_out;
    end

    assign o_rec_valid = r_out_valid;
    assign o_rec       = r_out;
endmodule

[rtl/bhrl_checker.sv]
// Port-level assertions on the record channel, bound to the top level.
`timescale 1ns / 1ps
module bhrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_boot_number,
    input logic [31:0] i_cause_bits,
    input logic        i_warm_flag,
    input logic        i_cause_valid,
    input logic [15:0] i_prior_uptime,
    input logic        i_record_present,
    input logic        i_last_record
);
    // a stalled record stays valid and keeps its boot number and last-record flag
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_boot_number)
            && $stable(i_last_record))
        else $error("record changed while stalled");

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_record_present |-> i_last_record
            && i_boot_number == 32'd0 && i_cause_bits == 32'd0
            && !i_warm_flag && !i_cause_valid && i_prior_uptime == 16'd0)
        else $error("empty marker carries data");

    a_cold_uptime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_record_present && !i_warm_flag
            |-> i_prior_uptime == 16'd0)
        else $error("cold boot record has prior uptime");

    a_cause_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_cause_valid |-> i_cause_bits != 32'd0)
        else $error("cause valid with empty cause");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("record valid right after reset");
endmodule

bind boot_history_ring_logger_core bhrl_checker u_bhrl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_rec.valid),
    .i_ready          (o_rec.ready),
    .i_boot_number    (o_rec.boot_number),
    .i_cause_bits     (o_rec.cause_bits),
    .i_warm_flag      (o_rec.warm_flag),
    .i_cause_valid    (o_rec.cause_valid),
    .i_prior_uptime   (o_rec.prior_uptime),
    .i_record_present (o_rec.record_present),
    .i_last_record    (o_rec.last_record)
);
